>>> design/lzbd_pkg.sv
`default_nettype none

package lzbd_pkg;

  // Widths of the fixed header fields and of a literal
  localparam logic [4:0] OFFW_BITS  = 5'd4;
  localparam logic [4:0] LENW_BITS  = 5'd4;
  localparam logic [4:0] MINL_BITS  = 5'd2;
  localparam logic [4:0] COUNT_BITS = 5'd16;
  localparam logic [4:0] LIT_BITS   = 5'd8;

  // Most bytes one input bit may produce; longer runs are cut here
  localparam logic [4:0] MAX_RUN = 5'd18;

  typedef enum logic [2:0] {
    PH_OFFW  = 3'd0,
    PH_LENW  = 3'd1,
    PH_MINL  = 3'd2,
    PH_COUNT = 3'd3,
    PH_FLAG  = 3'd4,
    PH_LIT   = 3'd5,
    PH_DIST  = 3'd6,
    PH_LEN   = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    E_IDLE = 2'd0,
    E_LIT  = 2'd1,
    E_RD   = 2'd2,
    E_WR   = 2'd3
  } eng_state_t;

  // Work handed from the parser to the output engine
  typedef struct packed {
    logic        restart;
    logic        valid;
    logic        is_copy;
    logic [7:0]  lit;
    logic [15:0] ref_dist;
    logic [4:0]  len;
    logic        last;
  } cmd_t;

endpackage

`default_nettype wire

>>> design/lzbd_if.sv
`default_nettype none

interface lzbd_bit_if;
  logic valid;
  logic ready;
  logic in_bit;
  logic stream_start;

  modport source (output valid, output in_bit, output stream_start, input ready);
  modport sink   (input valid, input in_bit, input stream_start, output ready);
endinterface

interface lzbd_byte_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [15:0] out_addr;
  logic        run_last;
  logic        stream_done;
  logic        bad_reference;

  modport source (output valid, output out_byte, output out_addr, output run_last,
                  output stream_done, output bad_reference, input ready);
  modport sink   (input valid, input out_byte, input out_addr, input run_last,
                  input stream_done, input bad_reference, output ready);
endinterface

interface lzbd_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] dest_base;

  modport source (output valid, output dest_base, input ready);
  modport sink   (input valid, input dest_base, output ready);
endinterface

`default_nettype wire

>>> design/lzbd_ram.sv
`default_nettype none

module lzbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32768
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> design/lzbd_parser.sv
`default_nettype none

module lzbd_parser
  import lzbd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic take,
  input  wire logic in_bit,
  input  wire logic stream_start,
  output cmd_t      cmd
);

  phase_t      phase_r, phase_nxt;
  logic [4:0]  bits_left_r, bits_left_nxt;
  logic [15:0] accum_r, accum_nxt;
  logic [3:0]  offw_r, offw_nxt;
  logic [3:0]  lenw_r, lenw_nxt;
  logic [1:0]  minl_r, minl_nxt;
  logic [15:0] tokens_r, tokens_nxt;
  logic [15:0] dist_r, dist_nxt;

  // Register view after an optional stream restart
  phase_t      eff_phase;
  logic [4:0]  eff_bl;
  logic [15:0] eff_acc;
  logic [3:0]  eff_offw;
  logic [3:0]  eff_lenw;
  logic [1:0]  eff_minl;
  logic [15:0] eff_tok;
  logic [15:0] eff_dist;

  logic [15:0] acc_sh;
  logic [4:0]  bl_dec;
  logic        in_field;
  logic        fdone;
  logic        tok_start;
  logic        ref_start;
  logic        lit_done;
  logic        dist_done;
  logic        copy_now;
  logic        token_end;
  logic [15:0] dist_val;
  logic [15:0] len_field;
  logic [16:0] len_full;
  logic [4:0]  len_cap;
  logic [15:0] tok_dec;

  // Decode the bit against the current phase and form the command
  always_comb begin
    eff_phase = stream_start ? PH_OFFW   : phase_r;
    eff_bl    = stream_start ? OFFW_BITS : bits_left_r;
    eff_acc   = stream_start ? 16'd0     : accum_r;
    eff_offw  = stream_start ? 4'd0      : offw_r;
    eff_lenw  = stream_start ? 4'd0      : lenw_r;
    eff_minl  = stream_start ? 2'd0      : minl_r;
    eff_tok   = stream_start ? 16'd0     : tokens_r;
    eff_dist  = stream_start ? 16'd0     : dist_r;

    acc_sh    = {eff_acc[14:0], in_bit};
    bl_dec    = (eff_bl != 5'd0) ? eff_bl - 5'd1 : 5'd0;
    in_field  = (eff_phase != PH_FLAG);
    fdone     = in_field && (bl_dec == 5'd0);
    tok_start = (eff_phase == PH_FLAG) && (eff_tok != 16'd0);
    ref_start = tok_start && in_bit;
    lit_done  = fdone && (eff_phase == PH_LIT);
    dist_done = fdone && (eff_phase == PH_DIST);
    // Zero-width fields complete at once, so a reference may finish on its flag
    copy_now  = (ref_start && (eff_offw == 4'd0) && (eff_lenw == 4'd0)) ||
                (dist_done && (eff_lenw == 4'd0)) ||
                (fdone && (eff_phase == PH_LEN));
    token_end = lit_done || copy_now;

    priority if (dist_done) begin
      dist_val = {1'b0, acc_sh[14:0]} + 16'd1;
    end else if (ref_start && (eff_offw == 4'd0)) begin
      dist_val = 16'd1;
    end else begin
      dist_val = eff_dist;
    end

    len_field = (eff_phase == PH_LEN) ? acc_sh : 16'd0;
    len_full  = {1'b0, len_field} + {15'd0, eff_minl};
    len_cap   = (len_full > {12'd0, MAX_RUN}) ? MAX_RUN : len_full[4:0];
    tok_dec   = eff_tok - 16'd1;

    cmd.restart  = stream_start;
    cmd.valid    = lit_done || (copy_now && (len_cap != 5'd0));
    cmd.is_copy  = copy_now;
    cmd.lit      = acc_sh[7:0];
    cmd.ref_dist = dist_val;
    cmd.len      = len_cap;
    cmd.last     = (tok_dec == 16'd0);
  end

  // Next parser state
  always_comb begin
    phase_nxt     = eff_phase;
    bits_left_nxt = eff_bl;
    accum_nxt     = eff_acc;
    offw_nxt      = eff_offw;
    lenw_nxt      = eff_lenw;
    minl_nxt      = eff_minl;
    tokens_nxt    = eff_tok;
    dist_nxt      = dist_val;

    if (in_field) begin
      accum_nxt     = acc_sh;
      bits_left_nxt = bl_dec;
    end

    if (tok_start && !in_bit) begin
      phase_nxt     = PH_LIT;
      bits_left_nxt = LIT_BITS;
      accum_nxt     = 16'd0;
    end

    if (ref_start && (eff_offw != 4'd0)) begin
      phase_nxt     = PH_DIST;
      bits_left_nxt = {1'b0, eff_offw};
      accum_nxt     = 16'd0;
    end

    if ((ref_start && (eff_offw == 4'd0) && (eff_lenw != 4'd0)) ||
        (dist_done && (eff_lenw != 4'd0))) begin
      phase_nxt     = PH_LEN;
      bits_left_nxt = {1'b0, eff_lenw};
      accum_nxt     = 16'd0;
    end

    if (fdone) begin
      unique case (eff_phase)
        PH_OFFW: begin
          offw_nxt      = acc_sh[3:0];
          phase_nxt     = PH_LENW;
          bits_left_nxt = LENW_BITS;
          accum_nxt     = 16'd0;
        end
        PH_LENW: begin
          lenw_nxt      = acc_sh[3:0];
          phase_nxt     = PH_MINL;
          bits_left_nxt = MINL_BITS;
          accum_nxt     = 16'd0;
        end
        PH_MINL: begin
          minl_nxt      = acc_sh[1:0];
          phase_nxt     = PH_COUNT;
          bits_left_nxt = COUNT_BITS;
          accum_nxt     = 16'd0;
        end
        PH_COUNT: begin
          tokens_nxt = acc_sh;
          phase_nxt  = PH_FLAG;
        end
        default: begin
        end
      endcase
    end

    if (token_end) begin
      tokens_nxt = tok_dec;
      phase_nxt  = PH_FLAG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_OFFW;
      bits_left_r <= OFFW_BITS;
      accum_r     <= 16'd0;
      offw_r      <= 4'd0;
      lenw_r      <= 4'd0;
      minl_r      <= 2'd0;
      tokens_r    <= 16'd0;
      dist_r      <= 16'd0;
    end else if (take) begin
      phase_r     <= phase_nxt;
      bits_left_r <= bits_left_nxt;
      accum_r     <= accum_nxt;
      offw_r      <= offw_nxt;
      lenw_r      <= lenw_nxt;
      minl_r      <= minl_nxt;
      tokens_r    <= tokens_nxt;
      dist_r      <= dist_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/lzbd_engine.sv
`default_nettype none

module lzbd_engine
  import lzbd_pkg::*;
#(
  parameter int HISTORY_DEPTH = 32768
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        take,
  input  wire cmd_t        cmd,
  input  wire logic [15:0] dest_base,
  input  wire logic        out_ready,
  output logic             idle,
  output logic             out_valid,
  output logic [7:0]       out_byte,
  output logic [15:0]      out_addr,
  output logic             run_last,
  output logic             stream_done,
  output logic             bad_reference
);

  localparam int          AW       = $clog2(HISTORY_DEPTH);
  localparam logic [16:0] DEPTH17  = 17'(HISTORY_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(HISTORY_DEPTH - 1);

  eng_state_t    state_r, state_nxt;
  logic [15:0]   pos_r, pos_nxt;
  logic [AW-1:0] hw_r, hw_nxt;
  logic          wrapped_r, wrapped_nxt;
  logic [7:0]    lit_r, lit_nxt;
  logic [15:0]   dist_r, dist_nxt;
  logic [4:0]    left_r, left_nxt;
  logic          last_r, last_nxt;
  logic          bad_r, bad_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_byte_r, out_byte_nxt;
  logic [15:0]   out_addr_r, out_addr_nxt;
  logic          run_last_r, run_last_nxt;
  logic          done_r, done_nxt;
  logic          obad_r, obad_nxt;

  logic          slot_free;
  logic          emit;
  logic [7:0]    emit_byte;
  logic          emit_bad;
  logic          bad_calc;
  logic [16:0]   hw17;
  logic [16:0]   d17;
  logic [16:0]   diff;
  logic [AW-1:0] rd_addr;
  logic          ram_re;
  logic [7:0]    ram_q;

  assign slot_free = !out_valid_r || out_ready;

  // Source address of the current copy byte, modulo the history depth
  always_comb begin
    hw17 = 17'(hw_r);
    d17  = {1'b0, dist_r};
    diff = hw17 - d17;
    if (hw17 < d17) begin
      diff = diff + DEPTH17;
    end
    rd_addr  = diff[AW-1:0];
    bad_calc = (d17 > DEPTH17) || (!wrapped_r && (dist_r > pos_r));
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      E_IDLE: begin
        if (take && cmd.valid) begin
          state_nxt = cmd.is_copy ? E_RD : E_LIT;
        end
      end
      E_LIT: begin
        if (slot_free) begin
          state_nxt = E_IDLE;
        end
      end
      E_RD: begin
        state_nxt = E_WR;
      end
      E_WR: begin
        if (slot_free) begin
          state_nxt = (left_r == 5'd1) ? E_IDLE : E_RD;
        end
      end
      default: begin
        state_nxt = E_IDLE;
      end
    endcase
  end

  // Datapath and outputs
  always_comb begin
    pos_nxt     = pos_r;
    hw_nxt      = hw_r;
    wrapped_nxt = wrapped_r;
    lit_nxt     = lit_r;
    dist_nxt    = dist_r;
    left_nxt    = left_r;
    last_nxt    = last_r;
    bad_nxt     = bad_r;
    ram_re      = 1'b0;
    emit        = 1'b0;
    emit_byte   = lit_r;
    emit_bad    = 1'b0;

    unique case (state_r)
      E_IDLE: begin
        if (take) begin
          if (cmd.restart) begin
            pos_nxt     = 16'd0;
            hw_nxt      = '0;
            wrapped_nxt = 1'b0;
          end
          if (cmd.valid) begin
            lit_nxt  = cmd.lit;
            dist_nxt = cmd.ref_dist;
            left_nxt = cmd.is_copy ? cmd.len : 5'd1;
            last_nxt = cmd.last;
          end
        end
      end
      E_LIT: begin
        emit = slot_free;
      end
      E_RD: begin
        ram_re  = 1'b1;
        bad_nxt = bad_calc;
      end
      E_WR: begin
        emit      = slot_free;
        emit_byte = bad_r ? 8'd0 : ram_q;
        emit_bad  = bad_r;
      end
      default: begin
      end
    endcase

    if (emit) begin
      left_nxt = left_r - 5'd1;
      pos_nxt  = pos_r + 16'd1;
      hw_nxt   = (hw_r == LAST_IDX) ? '0 : hw_r + 1'b1;
      if (pos_r == 16'hFFFF) begin
        wrapped_nxt = 1'b1;
      end
    end

    out_valid_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
    out_byte_nxt  = emit ? emit_byte : out_byte_r;
    out_addr_nxt  = emit ? dest_base + pos_r : out_addr_r;
    run_last_nxt  = emit ? (left_r == 5'd1) : run_last_r;
    done_nxt      = emit ? (last_r && (left_r == 5'd1)) : done_r;
    obad_nxt      = emit ? emit_bad : obad_r;
  end

  // One byte per read/write pair: the write of a byte lands before the next
  // read issues, so overlapping copies see their own output
  lzbd_ram #(
    .WIDTH (8),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (emit),
    .waddr (hw_r),
    .wdata (emit_byte),
    .re    (ram_re),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= E_IDLE;
      pos_r       <= 16'd0;
      hw_r        <= '0;
      wrapped_r   <= 1'b0;
      out_valid_r <= 1'b0;
      left_r      <= 5'd0;
      last_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      hw_r        <= hw_nxt;
      wrapped_r   <= wrapped_nxt;
      out_valid_r <= out_valid_nxt;
      left_r      <= left_nxt;
      last_r      <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lit_r      <= lit_nxt;
    dist_r     <= dist_nxt;
    bad_r      <= bad_nxt;
    out_byte_r <= out_byte_nxt;
    out_addr_r <= out_addr_nxt;
    run_last_r <= run_last_nxt;
    done_r     <= done_nxt;
    obad_r     <= obad_nxt;
  end

  assign idle          = (state_r == E_IDLE);
  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_addr      = out_addr_r;
  assign run_last      = run_last_r;
  assign stream_done   = done_r;
  assign bad_reference = obad_r;

endmodule

`default_nettype wire

>>> design/lz_bitstream_decompressor_core.sv
`default_nettype none

// Channel   Dir  Payload                                              Beat
// in_ch     in   in_bit, stream_start                                 one compressed bit
// out_ch    out  out_byte, out_addr, run_last, stream_done,           one decoded byte
//                bad_reference
// cfg_ch    in   dest_base                                            one register write
//
// Input: a bit that ends no token leaves the input open. A bit that ends a
// literal closes the input until its byte is emitted. A bit that ends a
// back-reference closes it while each copied byte (up to 18 bytes) takes a
// read and then a write of the history memory.
// Reset: synchronous, active low; parser and pointers clear at once. The
// history memory is not cleared, so there is no clearing pass.
// Stalls: a held output beat stalls byte emission; the input stays open while
// a finished byte waits in the output register.

module lz_bitstream_decompressor_core
  import lzbd_pkg::*;
#(
  parameter int HISTORY_DEPTH = 32768
) (
  input wire logic    clk,
  input wire logic    rst_n,
  lzbd_bit_if.sink    in_ch,
  lzbd_byte_if.source out_ch,
  lzbd_cfg_if.sink    cfg_ch
);

  logic [15:0] dest_base_r;
  logic        take;
  logic        eng_idle;
  cmd_t        cmd;

  // Write configuration only while the block is idle; not enforced; always accept
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_base_r <= 16'd0;
    end else if (cfg_ch.valid) begin
      dest_base_r <= cfg_ch.dest_base;
    end
  end

  // Take a bit whenever the engine has no byte work queued
  assign in_ch.ready = eng_idle;
  assign take        = in_ch.valid && eng_idle;

  lzbd_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .in_bit       (in_ch.in_bit),
    .stream_start (in_ch.stream_start),
    .cmd          (cmd)
  );

  lzbd_engine #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .take          (take),
    .cmd           (cmd),
    .dest_base     (dest_base_r),
    .out_ready     (out_ch.ready),
    .idle          (eng_idle),
    .out_valid     (out_ch.valid),
    .out_byte      (out_ch.out_byte),
    .out_addr      (out_ch.out_addr),
    .run_last      (out_ch.run_last),
    .stream_done   (out_ch.stream_done),
    .bad_reference (out_ch.bad_reference)
  );

  // A bit that produces bytes must close the input on the next cycle
  a_cmd_closes_input: assert property (@(posedge clk) disable iff (!rst_n)
    (take && cmd.valid) |=> !in_ch.ready)
    else $error("input still open after a byte-producing bit");

  // End of stream only ever marks the last byte of its bit
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.stream_done) |-> out_ch.run_last)
    else $error("stream_done without run_last");

  // A flagged reference always carries a zero byte
  a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.bad_reference) |-> (out_ch.out_byte == 8'd0))
    else $error("bad reference with nonzero byte");

endmodule

`default_nettype wire
